FILE: rtl/core/usd_pkg.sv
// ----------------------------------------------------------------------------
// usd_pkg
// Shared types and constants of the UTF-8 stream decoder: byte classes,
// the command passed from front to back, the result item and status codes.
// ----------------------------------------------------------------------------
package usd_pkg;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_AW    = $clog2(CMD_DEPTH);
    localparam int CMD_CW    = $clog2(CMD_DEPTH + 1);

    localparam int RES_DEPTH = 4;
    localparam int RES_AW    = $clog2(RES_DEPTH);
    localparam int RES_CW    = $clog2(RES_DEPTH + 1);

    localparam int CP_W  = 31;
    localparam int LEN_W = 3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_STRAY  = 2'd1;
    localparam logic [1:0] ST_BROKEN = 2'd2;

    typedef enum logic [1:0] {
        KIND_ASCII,
        KIND_CONT,
        KIND_LEAD
    } t_kind;

    // One classified byte. payload holds the bits the byte contributes:
    // seven for ASCII, six for a continuation, the lead's bits otherwise.
    typedef struct packed {
        t_kind            kind;
        logic [LEN_W-1:0] total;
        logic [6:0]       payload;
    } t_cmd;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] seq_length;
        logic [1:0]       status;
        logic             last;
    } t_result;

endpackage

FILE: rtl/core/usd_front.sv
// ----------------------------------------------------------------------------
// usd_front
// Accepts raw bytes, classifies each as ASCII, continuation or lead, and
// queues the classified command for the back end.
// ----------------------------------------------------------------------------
module usd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  logic [7:0]    i_in_byte,
    output logic          o_cmd_valid,
    output usd_pkg::t_cmd o_cmd,
    input  logic          i_cmd_take
);

    usd_pkg::t_cmd                 r_q [usd_pkg::CMD_DEPTH];
    logic [usd_pkg::CMD_AW-1:0]    r_wr, n_wr;
    logic [usd_pkg::CMD_AW-1:0]    r_rd, n_rd;
    logic [usd_pkg::CMD_CW-1:0]    r_cnt, n_cnt;
    usd_pkg::t_cmd                 w_cls;
    logic                          w_put;
    logic                          w_get;

    always_comb begin
        w_cls.kind    = usd_pkg::KIND_LEAD;
        w_cls.total   = usd_pkg::LEN_W'(1);
        w_cls.payload = i_in_byte[6:0];
        if (!i_in_byte[7]) begin
            w_cls.kind = usd_pkg::KIND_ASCII;
        end else if (!i_in_byte[6]) begin
            w_cls.kind    = usd_pkg::KIND_CONT;
            w_cls.payload = {1'b0, i_in_byte[5:0]};
        end else if (i_in_byte < 8'hE0) begin
            w_cls.total   = usd_pkg::LEN_W'(2);
            w_cls.payload = {2'b0, i_in_byte[4:0]};
        end else if (i_in_byte < 8'hF0) begin
            w_cls.total   = usd_pkg::LEN_W'(3);
            w_cls.payload = {3'b0, i_in_byte[3:0]};
        end else if (i_in_byte < 8'hF8) begin
            w_cls.total   = usd_pkg::LEN_W'(4);
            w_cls.payload = {4'b0, i_in_byte[2:0]};
        end else if (i_in_byte < 8'hFC) begin
            w_cls.total   = usd_pkg::LEN_W'(5);
            w_cls.payload = {5'b0, i_in_byte[1:0]};
        end else begin
            // 0xFC and above, 0xFE and 0xFF included, open six-byte sequences.
            w_cls.total   = usd_pkg::LEN_W'(6);
            w_cls.payload = {6'b0, i_in_byte[0]};
        end
    end

    assign full        = (r_cnt == usd_pkg::CMD_CW'(usd_pkg::CMD_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rd];
    assign w_put       = push && !full;
    assign w_get       = i_cmd_take && o_cmd_valid;

    always_comb begin
        n_wr  = w_put ? r_wr + usd_pkg::CMD_AW'(1) : r_wr;
        n_rd  = w_get ? r_rd + usd_pkg::CMD_AW'(1) : r_rd;
        n_cnt = r_cnt + usd_pkg::CMD_CW'(w_put) - usd_pkg::CMD_CW'(w_get);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_put) begin
            r_q[r_wr] <= w_cls;
        end
    end

endmodule

FILE: rtl/core/usd_back.sv
// ----------------------------------------------------------------------------
// usd_back
// Carries out classified commands: keeps the open sequence, gathers payload
// bits and writes up to two result items per command into the result queue.
// ----------------------------------------------------------------------------
module usd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  usd_pkg::t_cmd    i_cmd,
    output logic             o_cmd_take,
    output logic             empty,
    input  logic             pop,
    output usd_pkg::t_result o_result
);

    usd_pkg::t_result                r_q [usd_pkg::RES_DEPTH];
    logic [usd_pkg::RES_AW-1:0]      r_wr, n_wr;
    logic [usd_pkg::RES_AW-1:0]      r_rd, n_rd;
    logic [usd_pkg::RES_CW-1:0]      r_cnt, n_cnt;

    logic [usd_pkg::LEN_W-1:0]       r_left, n_left;
    logic [usd_pkg::CP_W-1:0]        r_bits, n_bits;
    logic [usd_pkg::LEN_W-1:0]       r_total, n_total;

    usd_pkg::t_result                w_res0;
    usd_pkg::t_result                w_res1;
    logic [1:0]                      w_nres;
    logic [usd_pkg::CP_W-1:0]        w_shifted;
    logic                            w_open;
    logic                            w_get;

    // A command is taken only when the queue has room for two results.
    assign o_cmd_take = i_cmd_valid
                     && (r_cnt <= usd_pkg::RES_CW'(usd_pkg::RES_DEPTH - 2));
    assign empty      = (r_cnt == '0);
    assign o_result   = r_q[r_rd];
    assign w_get      = pop && !empty;
    assign w_open     = (r_left != '0);
    assign w_shifted  = {r_bits[usd_pkg::CP_W-7:0], i_cmd.payload[5:0]};

    always_comb begin
        n_left  = r_left;
        n_bits  = r_bits;
        n_total = r_total;
        w_nres  = 2'd0;
        w_res0  = '{code_point: '0, seq_length: '0, status: usd_pkg::ST_BROKEN, last: 1'b1};
        w_res1  = '{code_point: usd_pkg::CP_W'(i_cmd.payload),
                    seq_length: usd_pkg::LEN_W'(1), status: usd_pkg::ST_OK, last: 1'b1};
        case (i_cmd.kind)
            usd_pkg::KIND_ASCII: begin
                n_left  = '0;
                n_bits  = '0;
                n_total = '0;
                if (w_open) begin
                    // Broken sequence: error first, then the ASCII byte itself.
                    w_res0.last = 1'b0;
                    w_nres      = 2'd2;
                end else begin
                    w_res0 = w_res1;
                    w_nres = 2'd1;
                end
            end
            usd_pkg::KIND_CONT: begin
                if (w_open) begin
                    n_left = r_left - usd_pkg::LEN_W'(1);
                    if (r_left == usd_pkg::LEN_W'(1)) begin
                        w_res0 = '{code_point: w_shifted, seq_length: r_total,
                                   status: usd_pkg::ST_OK, last: 1'b1};
                        w_nres  = 2'd1;
                        n_bits  = '0;
                        n_total = '0;
                    end else begin
                        n_bits = w_shifted;
                    end
                end else begin
                    w_res0.status = usd_pkg::ST_STRAY;
                    w_nres        = 2'd1;
                end
            end
            usd_pkg::KIND_LEAD: begin
                if (w_open) begin
                    w_nres = 2'd1;
                end
                n_bits  = usd_pkg::CP_W'(i_cmd.payload);
                n_left  = i_cmd.total - usd_pkg::LEN_W'(1);
                n_total = i_cmd.total;
            end
            default: begin
                w_nres = 2'd0;
            end
        endcase
        if (!o_cmd_take) begin
            n_left  = r_left;
            n_bits  = r_bits;
            n_total = r_total;
            w_nres  = 2'd0;
        end
    end

    always_comb begin
        n_wr  = r_wr + usd_pkg::RES_AW'(w_nres);
        n_rd  = w_get ? r_rd + usd_pkg::RES_AW'(1) : r_rd;
        n_cnt = r_cnt + usd_pkg::RES_CW'(w_nres) - usd_pkg::RES_CW'(w_get);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_cnt   <= '0;
            r_left  <= '0;
            r_bits  <= '0;
            r_total <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_cnt   <= n_cnt;
            r_left  <= n_left;
            r_bits  <= n_bits;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_nres != 2'd0) begin
            r_q[r_wr] <= w_res0;
        end
        if (w_nres == 2'd2) begin
            r_q[r_wr + usd_pkg::RES_AW'(1)] <= w_res1;
        end
    end

endmodule

FILE: rtl/core/utf8_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// Path: a byte is registered in the command queue, its results in the result
// queue. Throughput: one byte per cycle while full is low; a byte that yields
// two results needs two pops, absorbed by the four-entry result queue.
// Reset: synchronous, active low; empties both queues and closes any open
// sequence. No clearing pass is needed.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    output logic        empty,
    input  logic        pop,
    output logic [30:0] o_code_point,
    output logic [2:0]  o_seq_length,
    output logic [1:0]  o_status,
    output logic        o_last
);

    logic             w_cmd_valid;
    usd_pkg::t_cmd    w_cmd;
    logic             w_cmd_take;
    usd_pkg::t_result w_result;

    usd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_byte   (i_in_byte),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_cmd_take)
    );

    usd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .empty       (empty),
        .pop         (pop),
        .o_result    (w_result)
    );

    assign o_code_point = w_result.code_point;
    assign o_seq_length = w_result.seq_length;
    assign o_status     = w_result.status;
    assign o_last       = w_result.last;

    // Error results carry no code point and no length.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != usd_pkg::ST_OK) |-> (o_code_point == '0 && o_seq_length == '0))
        else $error("error result with nonzero payload");

    // A good result has a length of one to six bytes.
    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == usd_pkg::ST_OK)
        |-> (o_seq_length != 3'd0 && o_seq_length <= 3'd6))
        else $error("good result with bad length");

    // A stray continuation is always the only result of its byte.
    a_stray_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == usd_pkg::ST_STRAY) |-> o_last)
        else $error("stray result not marked last");

    // The back end never takes a command the front has not queued.
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_take |-> w_cmd_valid)
        else $error("command taken from empty queue");

endmodule

FILE: sim/usd_checker.sv
// ----------------------------------------------------------------------------
// usd_checker
// Watches the byte and result queues of the UTF-8 stream decoder, predicts the
// results of every accepted byte and compares each popped result, field by
// field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module usd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [7:0]  i_in_byte,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [30:0] i_code_point,
    input  logic [2:0]  i_seq_length,
    input  logic [1:0]  i_status,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [2:0]        cont_left;
    logic [30:0]       gathered;
    logic [2:0]        open_length;
    usd_pkg::t_result  awaited_decodes [$];
    int                fails;

    initial begin
        cont_left    = '0;
        gathered     = '0;
        open_length  = '0;
        fails        = 0;
        o_fail_count = 0;
        o_waiting    = 0;
    end

    task automatic add_decode(input logic [30:0] cp, input logic [2:0] len,
                              input logic [1:0] st, input logic lst);
        usd_pkg::t_result item;
        item.code_point = cp;
        item.seq_length = len;
        item.status     = st;
        item.last       = lst;
        awaited_decodes.push_back(item);
    endtask

    // Treats a byte as the start of a new sequence. Reports whether it
    // produced a result at once.
    task automatic start_sequence(input logic [7:0] b, output bit emitted);
        emitted = 1'b1;
        if (!b[7]) begin
            add_decode({24'd0, b[6:0]}, 3'd1, usd_pkg::ST_OK, 1'b1);
        end else if (!b[6]) begin
            add_decode('0, '0, usd_pkg::ST_STRAY, 1'b1);
        end else begin
            emitted = 1'b0;
            if (!b[5]) begin
                gathered = {26'd0, b[4:0]};
                cont_left = 3'd1;
                open_length = 3'd2;
            end else if (!b[4]) begin
                gathered = {27'd0, b[3:0]};
                cont_left = 3'd2;
                open_length = 3'd3;
            end else if (!b[3]) begin
                gathered = {28'd0, b[2:0]};
                cont_left = 3'd3;
                open_length = 3'd4;
            end else if (!b[2]) begin
                gathered = {29'd0, b[1:0]};
                cont_left = 3'd4;
                open_length = 3'd5;
            end else begin
                // 0xFC through 0xFF all open a six-byte sequence.
                gathered = {30'd0, b[0]};
                cont_left = 3'd5;
                open_length = 3'd6;
            end
        end
    endtask

    task automatic decode_byte(input logic [7:0] b);
        bit emitted;
        if (cont_left == 3'd0) begin
            start_sequence(b, emitted);
        end else if (b[7:6] == 2'b10) begin
            gathered = {gathered[24:0], b[5:0]};
            cont_left = cont_left - 3'd1;
            if (cont_left == 3'd0) begin
                add_decode(gathered, open_length, usd_pkg::ST_OK, 1'b1);
                gathered = '0;
                open_length = '0;
            end
        end else begin
            // The open sequence is dropped and the byte is looked at again
            // as the start of a new sequence; the error is final only if nothing follows it.
            cont_left = '0;
            gathered = '0;
            open_length = '0;
            add_decode('0, '0, usd_pkg::ST_BROKEN, 1'b1);
            start_sequence(b, emitted);
            if (emitted) begin
                awaited_decodes[awaited_decodes.size() - 2].last = 1'b0;
            end
        end
    endtask

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $realtime, what, want, got);
            fails++;
        end
    endtask

    task automatic check_result();
        usd_pkg::t_result want;
        if (awaited_decodes.size() == 0) begin
            $display({"%0t: unexpected result, expected none, ",
                      "actual cp 0x%0h len %0d st %0d last %0d"},
                     $realtime, i_code_point, i_seq_length, i_status, i_last);
            fails++;
        end else begin
            want = awaited_decodes.pop_front();
            compare_field("code_point", 32'(want.code_point), 32'(i_code_point));
            compare_field("seq_length", 32'(want.seq_length), 32'(i_seq_length));
            compare_field("status", 32'(want.status), 32'(i_status));
            compare_field("last", 32'(want.last), 32'(i_last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cont_left = '0;
            gathered = '0;
            open_length = '0;
            awaited_decodes.delete();
        end else begin
            if (i_push && !i_full) begin
                decode_byte(i_in_byte);
            end
            if (i_pop && !i_empty) begin
                check_result();
            end
        end
        o_fail_count <= fails;
        o_waiting <= awaited_decodes.size();
    end

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the UTF-8 stream decoder with a directed set of byte sequences and
// then with random well-formed, truncated and noise sequences under three
// patterns of idling on both sides, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_BYTES = 160;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_in_byte = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [30:0] o_code_point;
    logic [2:0]  o_seq_length;
    logic [1:0]  o_status;
    logic        o_last;

    int fail_count;
    int waiting;
    int tx_idle_pct = 25;
    int rx_idle_pct = 58;
    int bytes_sent = 0;
    int quiet_cycles = 0;

    // Every lead class, both ends of the byte range, a stray continuation
    // and broken sequences followed by a new lead and by an ASCII byte.
    logic [7:0] directed_bytes [$] = '{
        8'h00, 8'h80,
        8'hC2, 8'hA9,
        8'hE2, 8'h82, 8'hAC,
        8'hF4, 8'h8F, 8'hBF, 8'hBF,
        8'hFB, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
        8'hFF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
        8'hE2, 8'hFC, 8'h7F
    };

    always #1 i_clk = ~i_clk;

    utf8_stream_decoder_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_in_byte    (i_in_byte),
        .empty        (empty),
        .pop          (pop),
        .o_code_point (o_code_point),
        .o_seq_length (o_seq_length),
        .o_status     (o_status),
        .o_last       (o_last)
    );

    usd_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_in_byte    (i_in_byte),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_code_point (o_code_point),
        .i_seq_length (o_seq_length),
        .i_status     (o_status),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_waiting    (waiting)
    );

    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("utf8_stream_decoder_unit test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Holds push high until the transfer happens at a clock edge.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_in_byte <= b;
        do begin
            @(posedge i_clk);
        end while (full);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Mostly well-formed sequences with random payload; some are cut short
    // and some bytes are pure noise.
    task automatic send_random_sequence();
        int         pick;
        int         len;
        int         keep;
        logic [7:0] lead;
        pick = $urandom_range(99);
        if (pick < 15) begin
            send_byte(8'($urandom_range(255)));
        end else begin
            len = $urandom_range(1, 6);
            case (len)
                1: lead = 8'($urandom_range(127));
                2: lead = 8'hC0 | 8'($urandom_range(31));
                3: lead = 8'hE0 | 8'($urandom_range(15));
                4: lead = 8'hF0 | 8'($urandom_range(7));
                5: lead = 8'hF8 | 8'($urandom_range(3));
                default: lead = 8'hFC | 8'($urandom_range(3));
            endcase
            keep = len;
            if (pick < 27 && len > 1) begin
                keep = $urandom_range(1, len - 1);
            end
            send_byte(lead);
            for (int i = 1; i < keep; i++) begin
                send_byte(8'h80 | 8'($urandom_range(63)));
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_bytes[i]) begin
            send_byte(directed_bytes[i]);
        end
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 25;
                    rx_idle_pct = 58;
                end
                1: begin
                    tx_idle_pct = 58;
                    rx_idle_pct = 25;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            bytes_sent = 0;
            while (bytes_sent < PHASE_BYTES) begin
                send_random_sequence();
            end
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("utf8_stream_decoder_unit test passed");
        end else begin
            $display("utf8_stream_decoder_unit test failed");
        end
        $finish;
    end

endmodule
